// ===== src/srde_pkg.sv =====
// srde_pkg: shared types, constants and helpers for the signed radix digit emitter.
// Used by srde_div and signed_radix_digit_emitter. No dependencies.
package srde_pkg;

   localparam int VALUE_W    = 32;
   localparam int RADIX_W    = 5;
   localparam int SYM_W      = 8;
   localparam int MAX_BASE   = 16;
   localparam int DIGIT_W    = 4;                     // digit index, below MAX_BASE
   localparam int ALPHA_W    = MAX_BASE * SYM_W;      // all symbol bytes
   localparam int CSR_DATA_W = 64;
   localparam int CSR_IDX_W  = 2;
   localparam int MAX_DIGITS = VALUE_W;               // base two worst case
   localparam int ND_W       = 6;                     // holds 0..MAX_DIGITS
   localparam int DIV_STEPS  = 8;                     // quotient bits per cycle
   localparam int DIV_CYCLES = VALUE_W / DIV_STEPS;
   localparam int DCNT_W     = $clog2(DIV_CYCLES);

   localparam logic [SYM_W-1:0] SYM_PLUS  = 8'h2B;
   localparam logic [SYM_W-1:0] SYM_MINUS = 8'h2D;
   localparam logic [SYM_W-1:0] SYM_SPACE = 8'h20;
   localparam logic [SYM_W-1:0] SYM_TOP   = 8'd126;
   localparam logic [SYM_W-1:0] SYM_NONE  = 8'h00;

   localparam logic [RADIX_W-1:0]    RADIX_RST   = 5'd10;
   localparam logic [RADIX_W-1:0]    RADIX_MIN   = 5'd2;
   localparam logic [RADIX_W-1:0]    RADIX_MAX   = RADIX_W'(MAX_BASE);
   localparam logic [CSR_DATA_W-1:0] SYM_LOW_RST = 64'h3736353433323130;
   localparam logic [CSR_DATA_W-1:0] SYM_HI_RST  = 64'h0000000000003938;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RADIX    = 2'd0,
      CSR_SYM_LOW  = 2'd1,
      CSR_SYM_HIGH = 2'd2
   } csr_idx_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIV,
      ST_DWAIT,
      ST_SIGN,
      ST_EMIT,
      ST_ERR
   } state_type;

   typedef struct packed {
      logic                  done;
      logic [VALUE_W-1:0]    quotient;
      logic [DIGIT_W-1:0]    remainder;
   } div_rsp_type;

   function automatic logic [SYM_W-1:0] sym_at(input logic [ALPHA_W-1:0] syms,
                                               input logic [DIGIT_W-1:0] idx);
      return syms[{idx, 3'b000} +: SYM_W];
   endfunction

endpackage

// ===== src/srde_div.sv =====
// srde_div: iterative unsigned divider of a 32-bit value by a small base,
// DIV_STEPS quotient bits per cycle. Depends on srde_pkg.
module srde_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [srde_pkg::VALUE_W-1:0]  dividend,
   input  logic [srde_pkg::RADIX_W-1:0]  divisor,
   output srde_pkg::div_rsp_type         rsp
);
   import srde_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DCNT_W-1:0]    cnt_ff, cnt_in;
   logic [VALUE_W-1:0]   quo_ff, quo_in;
   logic [DIGIT_W-1:0]   rem_ff, rem_in;

   always_comb begin
      logic [RADIX_W-1:0] r;
      logic [VALUE_W-1:0] q;
      r       = {1'b0, rem_ff};
      q       = quo_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         // restoring steps; remainder stays below divisor, so four bits hold it
         for (int s = 0; s < DIV_STEPS; s++) begin
            r = {r[DIGIT_W-1:0], q[VALUE_W-1]};
            q = {q[VALUE_W-2:0], 1'b0};
            if (r >= divisor) begin
               r    = r - divisor;
               q[0] = 1'b1;
            end
         end
         quo_in = q;
         rem_in = r[DIGIT_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DCNT_W'(DIV_CYCLES - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign rsp.done      = done_ff;
   assign rsp.quotient  = quo_ff;
   assign rsp.remainder = rem_ff;

`ifndef ASSERT_OFF
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("divider done held for more than one cycle");
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("divider done without a running division");
   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      (done_ff && divisor >= RADIX_MIN && divisor <= RADIX_MAX)
         |-> ({1'b0, rem_ff} < divisor))
      else $error("remainder not below divisor");
`endif

endmodule

// ===== src/signed_radix_digit_emitter.sv =====
// signed_radix_digit_emitter: renders a signed 32-bit value as text in a configured base.
// Depends on srde_pkg and srde_div.
//
//  channel | dir | handshake             | payload
//  req     | in  | req_tvalid/req_tready | tdata[31:0] value (signed)
//  rsp     | out | rsp_tvalid/rsp_tready | tdata[7:0] symbol, tlast last, tuser error
//  csr     | in  | csr_valid/csr_ready   | csr_index register, csr_data[63:0] value
//
// One value per transaction; req_tready is high only while the block is idle.
// Steps per value: accept, alphabet check over radix symbols, one shared-divider run
//   per digit (8 quotient bits a cycle), sign step, emit per digit; errors stop early.
// Worst case is base two with the most negative value; rsp stalls hold sign and emit.
// Synchronous active-high reset restores radix 10 and the alphabet "0123456789".
// csr writes are always taken; they are meant to happen only while idle.
module signed_radix_digit_emitter (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [srde_pkg::VALUE_W-1:0]     req_tdata,   // [31:0] value
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [srde_pkg::SYM_W-1:0]       rsp_tdata,   // [7:0] symbol
   output logic                             rsp_tlast,   // last
   output logic                             rsp_tuser,   // [0] error
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [srde_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [srde_pkg::CSR_DATA_W-1:0]  csr_data
);
   import srde_pkg::*;

   logic [RADIX_W-1:0]    radix_ff;
   logic [CSR_DATA_W-1:0] sym_low_ff, sym_high_ff;
   logic [ALPHA_W-1:0]    alpha;

   state_type             state_ff, state_in;
   logic [DIGIT_W-1:0]    idx_ff, idx_in;
   logic                  neg_ff, neg_in;
   logic [VALUE_W-1:0]    mag_ff, mag_in;
   logic [ND_W-1:0]       nd_ff, nd_in;
   logic [DIGIT_W-1:0]    digits_ff [MAX_DIGITS];

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [SYM_W-1:0]      rsp_sym_ff, rsp_sym_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  rsp_err_ff, rsp_err_in;

   logic                  div_start;
   div_rsp_type           div_rsp;
   logic                  push;
   logic                  slot_free;
   logic                  radix_bad;
   logic                  sym_bad;
   logic [SYM_W-1:0]      cur_sym;
   logic [ND_W-1:0]       nd_m1;
   logic [DIGIT_W-1:0]    top_digit;

   assign alpha     = {sym_high_ff, sym_low_ff};
   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff    <= RADIX_RST;
         sym_low_ff  <= SYM_LOW_RST;
         sym_high_ff <= SYM_HI_RST;
      end else if (csr_valid) begin
         case (csr_idx_type'(csr_index))
            CSR_RADIX:    radix_ff    <= csr_data[RADIX_W-1:0];
            CSR_SYM_LOW:  sym_low_ff  <= csr_data;
            CSR_SYM_HIGH: sym_high_ff <= csr_data;
            default:      ;
         endcase
      end
   end

   srde_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (mag_ff),
      .divisor  (radix_ff),
      .rsp      (div_rsp)
   );

   // radix and alphabet check, one symbol per cycle against every later in-radix symbol
   assign radix_bad = (radix_ff < RADIX_MIN) || (radix_ff > RADIX_MAX);
   assign cur_sym   = sym_at(alpha, idx_ff);

   always_comb begin
      sym_bad = (cur_sym == SYM_PLUS) || (cur_sym == SYM_MINUS) ||
                (cur_sym <= SYM_SPACE) || (cur_sym > SYM_TOP);
      for (int j = 0; j < MAX_BASE; j++) begin
         if ((RADIX_W'(j) > {1'b0, idx_ff}) && (RADIX_W'(j) < radix_ff) &&
             (sym_at(alpha, DIGIT_W'(j)) == cur_sym))
            sym_bad = 1'b1;
      end
   end

   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign nd_m1     = nd_ff - 1'b1;
   assign top_digit = digits_ff[nd_m1[ND_W-2:0]];
   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      nd_in        = nd_ff;
      div_start    = 1'b0;
      push         = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_sym_in   = rsp_sym_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_err_in   = rsp_err_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               neg_in   = req_tdata[VALUE_W-1];
               mag_in   = req_tdata[VALUE_W-1] ? (~req_tdata + 1'b1) : req_tdata;
               idx_in   = '0;
               nd_in    = '0;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (radix_bad || sym_bad)
               state_in = ST_ERR;
            else if ({1'b0, idx_ff} == radix_ff - 1'b1)
               state_in = ST_DIV;
            else
               idx_in = idx_ff + 1'b1;
         end
         ST_DIV: begin
            div_start = 1'b1;
            state_in  = ST_DWAIT;
         end
         ST_DWAIT: begin
            if (div_rsp.done) begin
               push   = 1'b1;
               nd_in  = nd_ff + 1'b1;
               mag_in = div_rsp.quotient;
               if ((div_rsp.quotient == '0) || (nd_ff == ND_W'(MAX_DIGITS - 1)))
                  state_in = ST_SIGN;
               else
                  state_in = ST_DIV;
            end
         end
         ST_SIGN: begin
            if (!neg_ff) begin
               state_in = ST_EMIT;
            end else if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_sym_in   = SYM_MINUS;
               rsp_last_in  = 1'b0;
               rsp_err_in   = 1'b0;
               state_in     = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_sym_in   = sym_at(alpha, top_digit);
               rsp_last_in  = (nd_ff == ND_W'(1));
               rsp_err_in   = 1'b0;
               nd_in        = nd_m1;
               if (nd_ff == ND_W'(1))
                  state_in = ST_IDLE;
            end
         end
         ST_ERR: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_sym_in   = SYM_NONE;
               rsp_last_in  = 1'b1;
               rsp_err_in   = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         nd_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         nd_ff        <= nd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      neg_ff      <= neg_in;
      mag_ff      <= mag_in;
      rsp_sym_ff  <= rsp_sym_in;
      rsp_last_ff <= rsp_last_in;
      rsp_err_ff  <= rsp_err_in;
   end

   // digit stack, least significant pushed first
   always_ff @(posedge clock) begin
      if (push)
         digits_ff[nd_ff[ND_W-2:0]] <= div_rsp.remainder;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_sym_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_err_ff;

`ifndef ASSERT_OFF
   a_nd_range: assert property (@(posedge clock) disable iff (reset)
      nd_ff <= ND_W'(MAX_DIGITS))
      else $error("digit count overflow");
   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (nd_ff == '0))
      else $error("digits left over at idle");
   a_err_form: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_err_ff) |-> (rsp_last_ff && rsp_sym_ff == SYM_NONE))
      else $error("malformed error transaction");
   a_done_wait: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_DWAIT))
      else $error("divider finished outside wait state");
   a_emit_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (nd_ff != '0))
      else $error("emit with empty digit stack");
`endif

endmodule
